/* design/mtep_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared types and codes for the track parser front end, queue and formatter.
// ----------------------------------------------------------------------------
package mtep_pkg;

  localparam int QDEPTH = 4;

  typedef enum logic [3:0] {
    PH_DELTA    = 4'd0,
    PH_STATUS   = 4'd1,
    PH_CTRL     = 4'd2,
    PH_SYSLEN   = 4'd3,
    PH_METATYPE = 4'd4,
    PH_METALEN  = 4'd5,
    PH_SKIP     = 4'd6,
    PH_COLLECT  = 4'd7
  } phase_e;

  typedef enum logic [3:0] {
    K_NOTE_ON    = 4'd0,
    K_NOTE_OFF   = 4'd1,
    K_CONTROLLER = 4'd2,
    K_PROGRAM    = 4'd3,
    K_BEND       = 4'd4,
    K_END        = 4'd5,
    K_TEMPO      = 4'd6,
    K_TIMESIG    = 4'd7,
    K_LOOP_BEGIN = 4'd8,
    K_LOOP_ENDB  = 4'd9,
    K_LOOP_END   = 4'd10,
    K_LABEL      = 4'd11,
    K_ERROR      = 4'd12
  } kind_e;

  typedef enum logic [2:0] {
    E_NO_STATUS  = 3'd0,
    E_TEMPO_SIZE = 3'd1,
    E_TS_SIZE    = 3'd2,
    E_DENOM      = 3'd3,
    E_TS_RANGE   = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    CFG_CHANNEL         = 2'd0,
    CFG_PASS_MODE       = 2'd1,
    CFG_CLOCKS_PER_BEAT = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] ST_META    = 8'hFF;
  localparam logic [3:0] ST_SYS_HI  = 4'hF;
  localparam logic [7:0] META_END   = 8'h2F;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] META_TSIG  = 8'h58;
  localparam logic [7:0] CH_OPEN    = 8'h5B;
  localparam logic [7:0] CH_CLOSE   = 8'h5D;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_CTRL     = 4'hB;
  localparam logic [3:0] HI_PROG     = 4'hC;
  localparam logic [3:0] HI_PRESS    = 4'hD;
  localparam logic [3:0] HI_BEND     = 4'hE;

  typedef struct packed {
    logic [3:0] channel;
    logic       pass_mode;
    logic [4:0] clocks_per_beat;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] abs_time;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [15:0] ts;
    err_e        err;
  } req_t;

endpackage

/* design/mtep_front.sv */
// ----------------------------------------------------------------------------
// MIDI track event parser front end
// Walks the track byte stream, keeps time and running status, and classifies
// each reportable event into a request for the formatter.
// ----------------------------------------------------------------------------
module mtep_front #(
  parameter int TIME_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mtep_pkg::cfg_t  cfg_i,
  input  logic            take_i,
  input  logic            op_i,
  input  logic [7:0]      data_i,
  output logic            req_valid_o,
  output mtep_pkg::req_t  req_o
);
  import mtep_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [7:0]             rs_q, rs_d;
  logic [TIME_BITS-1:0]   time_q, time_d;
  logic [31:0]            len_q, len_d;
  logic [31:0]            skip_q, skip_d;
  logic [7:0]             meta_q, meta_d;
  logic [7:0]             fb_q [4];
  logic [7:0]             fb_d [4];
  logic [2:0]             fidx_q, fidx_d;
  logic                   done_q, done_d;

  logic        act;
  logic [31:0] acc;
  logic        last;
  logic        size1;
  logic [2:0]  nidx;
  logic [31:0] skip_nx;
  logic        is_text;
  logic [12:0] prod;
  logic [19:0] ticks;
  logic [19:0] tsv;
  logic        ts_bad;
  logic        ctrl_fire;
  kind_e       ctrl_kind;
  logic        fire;
  kind_e       kind;
  err_e        err;
  logic        halt;

  assign act     = take_i && !op_i && !done_q;
  assign acc     = {len_q[24:0], data_i[6:0]};
  assign last    = !data_i[7];
  assign size1   = (rs_q[7:4] == HI_PROG) || (rs_q[7:4] == HI_PRESS);
  assign nidx    = fidx_q + 3'd1;
  assign skip_nx = skip_q - {31'd0, (skip_q != 32'd0)};
  assign is_text = (meta_q >= 8'd1) && (meta_q <= 8'd7);

  always_comb begin
    for (int i = 0; i < 4; i++) fb_d[i] = fb_q[i];
    if (act) begin
      if (phase_q == PH_STATUS && last && rs_q[7]) begin
        fb_d[0] = data_i;
      end else if (phase_q == PH_CTRL || phase_q == PH_COLLECT) begin
        fb_d[fidx_q[1:0]] = data_i;
      end
    end
  end

  assign prod   = {5'd0, fb_d[0]} * {8'd0, cfg_i.clocks_per_beat};
  assign ticks  = {1'b0, prod, 6'd0} + {2'b0, prod, 5'd0};
  assign tsv    = ticks >> fb_d[1][3:0];
  assign ts_bad = (tsv == 20'd0) || (tsv[19:16] != 4'd0);

  always_comb begin
    ctrl_fire = !cfg_i.pass_mode && (rs_q[3:0] == cfg_i.channel);
    ctrl_kind = K_NOTE_OFF;
    unique case (rs_q[7:4])
      HI_NOTE_OFF: ctrl_kind = K_NOTE_OFF;
      HI_NOTE_ON:  ctrl_kind = (fb_d[1] == 8'd0) ? K_NOTE_OFF : K_NOTE_ON;
      HI_CTRL:     ctrl_kind = K_CONTROLLER;
      HI_PROG:     ctrl_kind = K_PROGRAM;
      HI_BEND:     ctrl_kind = K_BEND;
      default:     ctrl_fire = 1'b0;
    endcase
  end

  // request decode
  always_comb begin
    fire = 1'b0;
    kind = K_END;
    err  = E_NO_STATUS;
    if (act) begin
      unique case (phase_q)
        PH_STATUS: begin
          if (last && !rs_q[7]) begin
            fire = 1'b1;
            kind = K_ERROR;
            err  = E_NO_STATUS;
          end else if (last && size1) begin
            fire = ctrl_fire;
            kind = ctrl_kind;
          end
        end
        PH_CTRL: begin
          if (nidx >= (size1 ? 3'd1 : 3'd2)) begin
            fire = ctrl_fire;
            kind = ctrl_kind;
          end
        end
        PH_METALEN: begin
          if (last) begin
            if (meta_q == META_END) begin
              fire = (acc == 32'd0);
              kind = K_END;
            end else if (cfg_i.pass_mode && meta_q == META_TEMPO && acc != 32'd3) begin
              fire = 1'b1;
              kind = K_ERROR;
              err  = E_TEMPO_SIZE;
            end else if (cfg_i.pass_mode && meta_q == META_TSIG && acc != 32'd4) begin
              fire = 1'b1;
              kind = K_ERROR;
              err  = E_TS_SIZE;
            end
          end
        end
        PH_SKIP: begin
          fire = (skip_nx == 32'd0) && (meta_q == META_END);
          kind = K_END;
        end
        PH_COLLECT: begin
          if (meta_q == META_TSIG) begin
            if (nidx == 3'd2 && data_i >= 8'd16) begin
              fire = 1'b1;
              kind = K_ERROR;
              err  = E_DENOM;
            end else if (nidx == 3'd4) begin
              fire = 1'b1;
              kind = ts_bad ? K_ERROR : K_TIMESIG;
              err  = E_TS_RANGE;
            end
          end else if (meta_q == META_TEMPO) begin
            fire = (nidx == 3'd3);
            kind = K_TEMPO;
          end else if ({29'd0, nidx} >= skip_q) begin
            if (nidx == 3'd1) begin
              fire = 1'b1;
              if (data_i == CH_OPEN) kind = K_LOOP_BEGIN;
              else if (data_i == CH_CLOSE) kind = K_LOOP_END;
              else if (data_i == CH_COLON) kind = K_LABEL;
              else fire = 1'b0;
            end else begin
              fire = (fb_d[0] == CH_CLOSE) && (data_i == CH_OPEN);
              kind = K_LOOP_ENDB;
            end
          end
        end
        default: fire = 1'b0;
      endcase
    end
  end

  assign halt = fire && (kind == K_END || kind == K_ERROR);

  always_comb begin
    req_valid_o    = fire;
    req_o.kind     = kind;
    req_o.abs_time = 32'(time_q);
    req_o.b0       = fb_d[0];
    req_o.b1       = fb_d[1];
    req_o.b2       = fb_d[2];
    req_o.ts       = tsv[15:0];
    req_o.err      = err;
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    rs_d    = rs_q;
    time_d  = time_q;
    len_d   = len_q;
    skip_d  = skip_q;
    meta_d  = meta_q;
    fidx_d  = fidx_q;
    done_d  = done_q;
    if (take_i && op_i) begin
      phase_d = PH_DELTA;
      rs_d    = 8'd0;
      time_d  = '0;
      len_d   = 32'd0;
      skip_d  = 32'd0;
      meta_d  = 8'd0;
      fidx_d  = 3'd0;
      done_d  = 1'b0;
    end else if (act) begin
      unique case (phase_q)
        PH_DELTA: begin
          len_d = acc;
          if (last) begin
            time_d  = time_q + acc[TIME_BITS-1:0];
            len_d   = 32'd0;
            phase_d = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (last) begin
            fidx_d  = size1 ? 3'd0 : 3'd1;
            phase_d = size1 ? PH_DELTA : PH_CTRL;
          end else begin
            len_d  = 32'd0;
            fidx_d = 3'd0;
            if (data_i == ST_META) begin
              rs_d    = 8'd0;
              phase_d = PH_METATYPE;
            end else if (data_i[7:4] == ST_SYS_HI) begin
              rs_d    = 8'd0;
              meta_d  = 8'd0;
              phase_d = PH_SYSLEN;
            end else begin
              rs_d    = data_i;
              phase_d = PH_CTRL;
            end
          end
        end
        PH_CTRL: begin
          fidx_d = nidx;
          if (nidx >= (size1 ? 3'd1 : 3'd2)) begin
            fidx_d  = 3'd0;
            phase_d = PH_DELTA;
          end
        end
        PH_METATYPE: begin
          meta_d  = data_i;
          len_d   = 32'd0;
          phase_d = PH_METALEN;
        end
        PH_SYSLEN, PH_METALEN: begin
          len_d = acc;
          if (last) begin
            len_d   = 32'd0;
            skip_d  = acc;
            phase_d = (acc == 32'd0) ? PH_DELTA : PH_SKIP;
            if (phase_q == PH_METALEN) begin
              fidx_d = 3'd0;
              if (meta_q != META_END && cfg_i.pass_mode) begin
                if (is_text) begin
                  if (acc == 32'd0) begin
                    phase_d = PH_DELTA;
                  end else if (acc <= 32'd2) begin
                    phase_d = PH_COLLECT;
                  end
                end else if (meta_q == META_TEMPO || meta_q == META_TSIG) begin
                  skip_d  = skip_q;
                  phase_d = PH_COLLECT;
                end
              end
            end
          end
        end
        PH_SKIP: begin
          skip_d = skip_nx;
          if (skip_nx == 32'd0) phase_d = PH_DELTA;
        end
        PH_COLLECT: begin
          fidx_d = nidx;
          if (meta_q == META_TSIG) begin
            if (nidx == 3'd4) phase_d = PH_DELTA;
          end else if (meta_q == META_TEMPO) begin
            if (nidx == 3'd3) phase_d = PH_DELTA;
          end else if ({29'd0, nidx} >= skip_q) begin
            phase_d = PH_DELTA;
          end
        end
        default: phase_d = PH_DELTA;
      endcase
      if (halt) begin
        phase_d = PH_DELTA;
        done_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DELTA;
      rs_q    <= 8'd0;
      time_q  <= '0;
      len_q   <= 32'd0;
      skip_q  <= 32'd0;
      meta_q  <= 8'd0;
      fidx_q  <= 3'd0;
      done_q  <= 1'b0;
      for (int i = 0; i < 4; i++) fb_q[i] <= 8'd0;
    end else begin
      phase_q <= phase_d;
      rs_q    <= rs_d;
      time_q  <= time_d;
      len_q   <= len_d;
      skip_q  <= skip_d;
      meta_q  <= meta_d;
      fidx_q  <= fidx_d;
      done_q  <= done_d;
      for (int i = 0; i < 4; i++) fb_q[i] <= fb_d[i];
    end
  end

endmodule

/* design/mtep_queue.sv */
// ----------------------------------------------------------------------------
// MIDI track event parser request queue
// Small first-in first-out buffer between the parser and the formatter.
// ----------------------------------------------------------------------------
module mtep_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  mtep_pkg::req_t  wr_data_i,
  output logic            full_o,
  input  logic            rd_i,
  output logic            valid_o,
  output mtep_pkg::req_t  rd_data_o
);
  import mtep_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  req_t          mem_q [QDEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic          do_wr, do_rd;

  assign full_o    = (cnt_q == CW'(QDEPTH));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rp_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= (wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + PW'(1);
      if (do_rd) rp_q <= (rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + PW'(1);
      cnt_q <= cnt_q + CW'(do_wr) - CW'(do_rd);
    end
  end

endmodule

/* design/mtep_back.sv */
// ----------------------------------------------------------------------------
// MIDI track event parser formatter
// Turns queued requests into result fields, numbers markers, and holds the
// result register toward the consumer.
// ----------------------------------------------------------------------------
module mtep_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  mtep_pkg::req_t  req_i,
  output logic            req_pop_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [3:0]      kind_o,
  output logic [31:0]     abs_time_o,
  output logic [6:0]      note_o,
  output logic [7:0]      param_a_o,
  output logic [23:0]     param_b_o,
  output logic [2:0]      error_code_o
);
  import mtep_pkg::*;

  logic        out_valid_q;
  logic [23:0] mcount_q;
  logic        take;
  logic        is_marker;
  logic [6:0]  note_d;
  logic [7:0]  pa_d;
  logic [23:0] pb_d;
  logic [2:0]  ec_d;

  assign take      = req_valid_i && (!out_valid_q || pop_i);
  assign req_pop_o = take;
  assign empty_o   = !out_valid_q;
  assign is_marker = (req_i.kind == K_LOOP_BEGIN) || (req_i.kind == K_LOOP_ENDB) ||
                     (req_i.kind == K_LOOP_END) || (req_i.kind == K_LABEL);

  always_comb begin
    note_d = 7'd0;
    pa_d   = 8'd0;
    pb_d   = 24'd0;
    ec_d   = 3'd0;
    unique case (req_i.kind)
      K_NOTE_ON, K_NOTE_OFF: begin
        note_d = req_i.b0[6:0];
        pa_d   = req_i.b1;
      end
      K_CONTROLLER, K_BEND: begin
        pa_d = req_i.b0;
        pb_d = {16'd0, req_i.b1};
      end
      K_PROGRAM: pa_d = req_i.b0;
      K_TEMPO:   pb_d = {req_i.b0, req_i.b1, req_i.b2};
      K_TIMESIG: pb_d = {8'd0, req_i.ts};
      K_LOOP_BEGIN, K_LOOP_ENDB, K_LOOP_END, K_LABEL: pb_d = mcount_q;
      K_ERROR:   ec_d = req_i.err;
      default:   ec_d = 3'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_o       <= req_i.kind;
      abs_time_o   <= req_i.abs_time;
      note_o       <= note_d;
      param_a_o    <= pa_d;
      param_b_o    <= pb_d;
      error_code_o <= ec_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mcount_q    <= 24'd0;
    end else begin
      if (take) out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
      if (take && is_marker) mcount_q <= mcount_q + 24'd1;
    end
  end

endmodule

/* design/midi_track_event_parser.sv */
// ----------------------------------------------------------------------------
// MIDI track event parser
// Accepts one track byte per cycle and reports channel or sequence events.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; input stalls only while the request queue is full.
// Path: an event is written into the request queue at the edge that accepts its
// last byte, then enters the output register when the formatter takes it.
// Reset: clears parser state, marker count, queue and output valid flag; configuration
// returns to channel 0, channel mode, one clock per beat.
module midi_track_event_parser #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  kind_o,
  output logic [31:0] abs_time_o,
  output logic [6:0]  note_o,
  output logic [7:0]  param_a_o,
  output logic [23:0] param_b_o,
  output logic [2:0]  error_code_o
);
  import mtep_pkg::*;

  cfg_t cfg_q;
  logic take;
  logic req_valid, q_valid, q_pop;
  req_t req, q_data;

  assign cfg_ready_o = 1'b1;
  assign take        = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel         <= 4'd0;
      cfg_q.pass_mode       <= 1'b0;
      cfg_q.clocks_per_beat <= 5'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CHANNEL:         cfg_q.channel         <= cfg_data_i[3:0];
        CFG_PASS_MODE:       cfg_q.pass_mode       <= cfg_data_i[0];
        CFG_CLOCKS_PER_BEAT: cfg_q.clocks_per_beat <= cfg_data_i;
        default:             cfg_q                 <= cfg_q;
      endcase
    end
  end

  mtep_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .take_i     (take),
    .op_i       (op_i),
    .data_i     (data_byte_i),
    .req_valid_o(req_valid),
    .req_o      (req)
  );

  mtep_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (req_valid),
    .wr_data_i(req),
    .full_o   (full),
    .rd_i     (q_pop),
    .valid_o  (q_valid),
    .rd_data_o(q_data)
  );

  mtep_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (q_valid),
    .req_i       (q_data),
    .req_pop_o   (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .kind_o      (kind_o),
    .abs_time_o  (abs_time_o),
    .note_o      (note_o),
    .param_a_o   (param_a_o),
    .param_b_o   (param_b_o),
    .error_code_o(error_code_o)
  );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI track event parser testbench
// Feeds track bytes through a queue driver and checks every reported event
// against a cycle-free parser model, over channel and sequence settings.
// ----------------------------------------------------------------------------
module tb_top;
  import mtep_pkg::*;

  localparam int LIMIT = 400000;
  localparam int HOLD  = 6;

  typedef enum logic [1:0] {T_ITEM, T_CFG, T_MODE, T_DRAIN} step_e;

  typedef struct {
    step_e      typ;
    logic       op;
    logic [7:0] data;
    cfg_idx_e   idx;
    logic [4:0] val;
    int         s_pct;
    int         r_pct;
  } step_t;

  typedef struct {
    kind_e       kind;
    logic [31:0] abs_time;
    logic [6:0]  note;
    logic [7:0]  param_a;
    logic [23:0] param_b;
    logic [2:0]  error_code;
  } event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [4:0]  cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic        op_i = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  kind_o;
  logic [31:0] abs_time_o;
  logic [6:0]  note_o;
  logic [7:0]  param_a_o;
  logic [23:0] param_b_o;
  logic [2:0]  error_code_o;

  midi_track_event_parser DUT (.*);

  always #5 clk_i = ~clk_i;

  step_t  stim_q[$];
  event_t event_q[$];
  int     send_pct = 0;
  int     recv_pct = 0;
  int     n_gen = 0;
  int     n_items = 0;
  int     n_events = 0;
  int     n_tracks = 0;
  int     n_errors = 0;
  int     cycles = 0;
  int     hold_cnt = 0;

  // parser mirror
  logic [3:0]  m_chan = '0;
  logic        m_pass = 1'b0;
  logic [4:0]  m_cpb = 5'd1;
  phase_e      ph = PH_DELTA;
  logic [7:0]  rs = '0;
  logic [31:0] at = '0;
  logic [31:0] lacc = '0;
  logic [31:0] skip = '0;
  logic [7:0]  mt = '0;
  logic [7:0]  fb[4] = '{default: '0};
  logic [2:0]  fi = '0;
  logic [23:0] mc = '0;
  logic        done = 1'b0;

  task automatic post(kind_e k, logic [6:0] n, logic [7:0] a, logic [23:0] b, logic [2:0] e);
    event_t ev;
    ev.kind = k; ev.abs_time = at; ev.note = n;
    ev.param_a = a; ev.param_b = b; ev.error_code = e;
    event_q.insert(event_q.size(), ev);
  endtask

  task automatic halt(kind_e k, logic [2:0] e);
    done = 1'b1;
    ph = PH_DELTA;
    post(k, '0, '0, '0, e);
  endtask

  function automatic logic one_byte_msg(logic [7:0] st);
    return st[7:4] == HI_PROG || st[7:4] == HI_PRESS;
  endfunction

  task automatic begin_skip(logic [31:0] len);
    skip = len;
    ph = (len == 0) ? PH_DELTA : PH_SKIP;
  endtask

  task automatic finish_msg();
    ph = PH_DELTA;
    fi = '0;
    if (m_pass || rs[3:0] != m_chan) return;
    case (rs[7:4])
      HI_NOTE_OFF: post(K_NOTE_OFF, fb[0][6:0], fb[1], '0, '0);
      HI_NOTE_ON: begin
        if (fb[1] == 0) post(K_NOTE_OFF, fb[0][6:0], '0, '0, '0);
        else post(K_NOTE_ON, fb[0][6:0], fb[1], '0, '0);
      end
      HI_CTRL: post(K_CONTROLLER, '0, fb[0], {16'd0, fb[1]}, '0);
      HI_PROG: post(K_PROGRAM, '0, fb[0], '0, '0);
      HI_BEND: post(K_BEND, '0, fb[0], {16'd0, fb[1]}, '0);
      default: ;
    endcase
  endtask

  task automatic meta_begin(logic [31:0] len);
    fi = '0;
    if (mt == META_END) begin
      if (len == 0) halt(K_END, '0);
      else begin_skip(len);
    end else if (!m_pass) begin
      begin_skip(len);
    end else if (mt >= 1 && mt <= 7) begin
      if (len == 0) ph = PH_DELTA;
      else if (len <= 2) begin
        skip = len;
        ph = PH_COLLECT;
      end else begin_skip(len);
    end else if (mt == META_TEMPO) begin
      if (len != 3) halt(K_ERROR, E_TEMPO_SIZE);
      else ph = PH_COLLECT;
    end else if (mt == META_TSIG) begin
      if (len != 4) halt(K_ERROR, E_TS_SIZE);
      else ph = PH_COLLECT;
    end else begin
      begin_skip(len);
    end
  endtask

  task automatic collect(logic [7:0] b);
    logic [31:0] ticks;
    kind_e       k;
    logic        hit;
    fb[fi[1:0]] = b;
    fi = fi + 3'd1;
    if (mt == META_TSIG) begin
      if (fi == 2 && b >= 16) begin
        halt(K_ERROR, E_DENOM);
      end else if (fi == 4) begin
        ticks = (32'd96 * fb[0] * m_cpb) >> fb[1][3:0];
        ph = PH_DELTA;
        if (ticks == 0 || ticks >= 32'h10000) halt(K_ERROR, E_TS_RANGE);
        else post(K_TIMESIG, '0, '0, ticks[23:0], '0);
      end
    end else if (mt == META_TEMPO) begin
      if (fi == 3) begin
        ph = PH_DELTA;
        post(K_TEMPO, '0, '0, {fb[0], fb[1], fb[2]}, '0);
      end
    end else if (32'(fi) >= skip) begin
      ph = PH_DELTA;
      hit = 1'b1;
      k = K_LOOP_BEGIN;
      if (fi == 1) begin
        if (fb[0] == CH_OPEN) k = K_LOOP_BEGIN;
        else if (fb[0] == CH_CLOSE) k = K_LOOP_END;
        else if (fb[0] == CH_COLON) k = K_LABEL;
        else hit = 1'b0;
      end else if (fb[0] == CH_CLOSE && fb[1] == CH_OPEN) k = K_LOOP_ENDB;
      else hit = 1'b0;
      if (hit) begin
        post(k, '0, '0, mc, '0);
        mc = mc + 24'd1;
      end
    end
  endtask

  task automatic track_step(logic op, logic [7:0] b);
    logic [31:0] len;
    if (op) begin
      ph = PH_DELTA; rs = '0; at = '0; lacc = '0; skip = '0;
      mt = '0; fi = '0; done = 1'b0;
      return;
    end
    if (done) return;
    case (ph)
      PH_DELTA: begin
        lacc = {lacc[24:0], b[6:0]};
        if (!b[7]) begin
          at = at + lacc;
          lacc = '0;
          ph = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (!b[7]) begin
          if (!rs[7]) halt(K_ERROR, E_NO_STATUS);
          else begin
            fb[0] = b;
            fi = 3'd1;
            if (one_byte_msg(rs)) finish_msg();
            else ph = PH_CTRL;
          end
        end else begin
          lacc = '0;
          fi = '0;
          if (b == ST_META) begin
            rs = '0; ph = PH_METATYPE;
          end else if (b[7:4] == ST_SYS_HI) begin
            rs = '0; mt = '0; ph = PH_SYSLEN;
          end else begin
            rs = b; ph = PH_CTRL;
          end
        end
      end
      PH_CTRL: begin
        fb[fi[1:0]] = b;
        fi = fi + 3'd1;
        if (fi >= (one_byte_msg(rs) ? 3'd1 : 3'd2)) finish_msg();
      end
      PH_METATYPE: begin
        mt = b; lacc = '0; ph = PH_METALEN;
      end
      PH_SYSLEN, PH_METALEN: begin
        lacc = {lacc[24:0], b[6:0]};
        if (!b[7]) begin
          len = lacc;
          lacc = '0;
          if (ph == PH_SYSLEN) begin_skip(len);
          else meta_begin(len);
        end
      end
      PH_SKIP: begin
        if (skip != 0) skip = skip - 1;
        if (skip == 0) begin
          ph = PH_DELTA;
          if (mt == META_END) halt(K_END, '0);
        end
      end
      PH_COLLECT: collect(b);
      default: ph = PH_DELTA;
    endcase
  endtask

  // driver
  logic  nxt_push, nxt_cfg;
  step_t cur;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      nxt_push = push && full;
      nxt_cfg = cfg_valid_i && !cfg_ready_o;
      if (push && !full) begin
        track_step(op_i, data_byte_i);
        n_items++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_CHANNEL: m_chan = cfg_data_i[3:0];
          CFG_PASS_MODE: m_pass = cfg_data_i[0];
          CFG_CLOCKS_PER_BEAT: m_cpb = cfg_data_i;
          default: ;
        endcase
      end
      if (!nxt_push && !nxt_cfg && stim_q.size() > 0) begin
        cur = stim_q[0];
        case (cur.typ)
          T_ITEM: begin
            if ($urandom_range(0, 99) >= send_pct) begin
              nxt_push = 1'b1;
              op_i <= cur.op;
              data_byte_i <= cur.data;
              void'(stim_q.pop_front());
            end
          end
          T_CFG: begin
            nxt_cfg = 1'b1;
            cfg_index_i <= cur.idx;
            cfg_data_i <= cur.val;
            void'(stim_q.pop_front());
          end
          T_MODE: begin
            send_pct = cur.s_pct;
            recv_pct = cur.r_pct;
            void'(stim_q.pop_front());
          end
          default: begin
            if (event_q.size() != 0) hold_cnt = 0;
            else if (hold_cnt >= HOLD) begin
              hold_cnt = 0;
              void'(stim_q.pop_front());
            end else hold_cnt++;
          end
        endcase
      end
      push <= nxt_push;
      cfg_valid_i <= nxt_cfg;
    end
  end

  // monitor
  event_t want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (!empty && pop) begin
        n_events++;
        if (event_q.size() == 0) begin
          $error("unexpected event kind %0d", kind_o);
          n_errors++;
        end else begin
          want = event_q.pop_front();
          if (kind_o !== want.kind) begin
            $error("kind: expected %0d actual %0d", want.kind, kind_o); n_errors++;
          end
          if (abs_time_o !== want.abs_time) begin
            $error("abs_time: expected %0h actual %0h", want.abs_time, abs_time_o);
            n_errors++;
          end
          if (note_o !== want.note) begin
            $error("note: expected %0h actual %0h", want.note, note_o); n_errors++;
          end
          if (param_a_o !== want.param_a) begin
            $error("param_a: expected %0h actual %0h", want.param_a, param_a_o);
            n_errors++;
          end
          if (param_b_o !== want.param_b) begin
            $error("param_b: expected %0h actual %0h", want.param_b, param_b_o);
            n_errors++;
          end
          if (error_code_o !== want.error_code) begin
            $error("error_code: expected %0d actual %0d", want.error_code, error_code_o);
            n_errors++;
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus builders
  task automatic add_byte(logic [7:0] b);
    step_t s;
    s = '{typ: T_ITEM, op: 1'b0, data: b, idx: CFG_CHANNEL, val: '0, s_pct: 0, r_pct: 0};
    stim_q.insert(stim_q.size(), s);
    n_gen++;
  endtask

  task automatic add_start();
    step_t s;
    s = '{typ: T_ITEM, op: 1'b1, data: 8'($urandom), idx: CFG_CHANNEL, val: '0,
          s_pct: 0, r_pct: 0};
    stim_q.insert(stim_q.size(), s);
    n_gen++;
    n_tracks++;
  endtask

  task automatic add_drain();
    step_t s;
    s = '{typ: T_DRAIN, op: 1'b0, data: '0, idx: CFG_CHANNEL, val: '0, s_pct: 0, r_pct: 0};
    stim_q.insert(stim_q.size(), s);
  endtask

  task automatic add_cfg(cfg_idx_e i, logic [4:0] v);
    step_t s;
    s = '{typ: T_CFG, op: 1'b0, data: '0, idx: i, val: v, s_pct: 0, r_pct: 0};
    stim_q.insert(stim_q.size(), s);
  endtask

  task automatic add_mode(int sp, int rp);
    step_t s;
    s = '{typ: T_MODE, op: 1'b0, data: '0, idx: CFG_CHANNEL, val: '0, s_pct: sp, r_pct: rp};
    stim_q.insert(stim_q.size(), s);
  endtask

  task automatic add_vlq(logic [31:0] v);
    int n;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    for (int i = n - 1; i >= 0; i--)
      add_byte({i != 0, 7'(v >> (7 * i))});
  endtask

  task automatic add_meta(logic [7:0] t, int len, logic [7:0] d0, logic [7:0] d1,
                          logic [7:0] d2, logic [7:0] d3);
    logic [7:0] d[4];
    d = '{d0, d1, d2, d3};
    add_byte(ST_META);
    add_byte(t);
    add_vlq(len);
    for (int i = 0; i < len; i++) add_byte(i < 4 ? d[i] : 8'($urandom));
  endtask

  task automatic add_delta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) add_vlq($urandom_range(0, 127));
    else if (r < 85) add_vlq($urandom_range(0, 20000));
    else if (r < 97) add_vlq($urandom);
    else for (int i = 0; i < 5; i++) add_byte({i != 4, 7'($urandom)});
  endtask

  task automatic add_event(logic [3:0] chan, logic pass, inout logic have_rs);
    int         r;
    logic [7:0] st;
    logic [7:0] txt[5];
    r = $urandom_range(0, 99);
    txt = '{CH_OPEN, CH_CLOSE, CH_COLON, 8'h41, 8'($urandom)};
    add_delta();
    if (r < (pass ? 20 : 60)) begin
      if (!(have_rs && $urandom_range(0, 2) == 0)) begin
        st = {1'b1, 3'($urandom_range(0, 6)), ($urandom_range(0, 3) == 0) ?
              4'($urandom) : chan};
        add_byte(st);
        have_rs = 1'b1;
      end
      add_byte($urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 127)));
      add_byte($urandom_range(0, 4) == 0 ? 8'h00 : 8'($urandom_range(0, 127)));
    end else if (r < (pass ? 35 : 65)) begin
      add_meta(META_TEMPO, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : 3,
               8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      have_rs = 1'b0;
    end else if (r < (pass ? 52 : 70)) begin
      add_meta(META_TSIG, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 4,
               8'($urandom_range(0, 12)),
               ($urandom_range(0, 14) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)),
               8'($urandom), 8'($urandom));
      have_rs = 1'b0;
    end else if (r < (pass ? 80 : 80)) begin
      add_meta(8'($urandom_range(1, 7)), $urandom_range(0, 4),
               txt[$urandom_range(0, 4)], txt[$urandom_range(0, 4)], 8'($urandom),
               8'($urandom));
      have_rs = 1'b0;
    end else if (r < 88) begin
      add_meta(8'($urandom), $urandom_range(0, 5), 8'($urandom), 8'($urandom),
               8'($urandom), 8'($urandom));
      have_rs = 1'b0;
    end else if (r < 96) begin
      add_byte({4'hF, 4'($urandom_range(0, 14))});
      r = $urandom_range(0, 5);
      add_vlq(r);
      for (int i = 0; i < r; i++) add_byte(8'($urandom));
      have_rs = 1'b0;
    end else begin
      add_byte(8'($urandom));
    end
  endtask

  task automatic add_track(logic [3:0] chan, logic pass);
    logic have_rs;
    have_rs = 1'b0;
    add_start();
    repeat ($urandom_range(3, 15)) add_event(chan, pass, have_rs);
    if ($urandom_range(0, 9) != 0) begin
      add_delta();
      add_meta(META_END, $urandom_range(0, 4) == 0 ? 1 : 0, 8'($urandom), 0, 0, 0);
    end
  endtask

  initial begin
    int   grp;
    logic [3:0] chan;
    logic pass;
    logic [4:0] cpb;
    // directed: channel mode, channel 15
    add_cfg(CFG_CHANNEL, 5'd15);
    add_start();
    add_vlq(0); add_byte(8'h9F); add_byte(8'h7F); add_byte(8'h7F);
    add_vlq(32'h0FFF_FFFF); add_byte(8'h00); add_byte(8'h00);
    add_vlq(1); add_byte(8'h8F); add_byte(8'h3C); add_byte(8'h40);
    add_vlq(2); add_byte(8'hBF); add_byte(8'h07); add_byte(8'h64);
    add_vlq(3); add_byte(8'hCF); add_byte(8'h05);
    add_vlq(0); add_byte(8'hDF); add_byte(8'h11);
    add_vlq(0); add_byte(8'hAF); add_byte(8'h11); add_byte(8'h22);
    add_vlq(0); add_byte(8'hEF); add_byte(8'h00); add_byte(8'h40);
    add_byte(8'h90); add_byte(8'h80); add_byte(8'h80); add_byte(8'h80); add_byte(8'h00);
    add_byte(8'hF0); add_byte(8'h90); add_byte(8'h80); add_byte(8'h80); add_byte(8'h80);
    add_byte(8'h02); add_byte(8'h01); add_byte(8'h02);
    add_vlq(0); add_meta(META_END, 0, 0, 0, 0, 0);
    add_start();
    add_vlq(5); add_byte(8'h40);
    add_drain();
    // directed: sequence mode, extreme beat clocks
    add_cfg(CFG_PASS_MODE, 5'd1);
    add_cfg(CFG_CLOCKS_PER_BEAT, 5'd16);
    add_start();
    add_vlq(0); add_meta(META_TEMPO, 3, 8'h07, 8'hA1, 8'h20, 0);
    add_vlq(0); add_meta(META_TSIG, 4, 8'd4, 8'd2, 8'd24, 8'd8);
    add_vlq(0); add_meta(8'h06, 1, CH_OPEN, 0, 0, 0);
    add_vlq(0); add_meta(8'h06, 2, CH_CLOSE, CH_OPEN, 0, 0);
    add_vlq(0); add_meta(8'h06, 1, CH_CLOSE, 0, 0, 0);
    add_vlq(0); add_meta(8'h01, 1, CH_COLON, 0, 0, 0);
    add_vlq(0); add_meta(8'h01, 0, 0, 0, 0, 0);
    add_vlq(0); add_meta(META_END, 2, 0, 0, 0, 0);
    add_start(); add_vlq(0); add_meta(META_TEMPO, 2, 1, 2, 0, 0);
    add_start(); add_vlq(0); add_meta(META_TSIG, 3, 1, 2, 3, 0);
    add_start(); add_vlq(0); add_meta(META_TSIG, 4, 1, 16, 0, 0);
    add_start(); add_vlq(0); add_meta(META_TSIG, 4, 255, 0, 0, 0);
    add_drain();
    add_cfg(CFG_CLOCKS_PER_BEAT, 5'd0);
    add_start(); add_vlq(0); add_meta(META_TSIG, 4, 4, 2, 0, 0);
    add_drain();
    add_cfg(CFG_CLOCKS_PER_BEAT, 5'd31);
    add_start(); add_vlq(0); add_meta(META_TSIG, 4, 255, 15, 0, 0);
    // random groups
    grp = 0;
    while (n_gen < 1750) begin
      add_drain();
      case (grp % 4)
        0: add_mode(0, 0);
        1: add_mode(58, 0);
        2: add_mode(0, 58);
        default: add_mode(29, 29);
      endcase
      chan = (grp % 5 == 0) ? 4'd0 : (grp % 5 == 1) ? 4'd15 : 4'($urandom);
      pass = (grp % 3 == 2);
      cpb = (grp % 7 == 0) ? 5'd1 : (grp % 7 == 1) ? 5'd16 : 5'($urandom_range(1, 16));
      add_cfg(CFG_CHANNEL, {1'b0, chan});
      add_cfg(CFG_PASS_MODE, {4'd0, pass});
      add_cfg(CFG_CLOCKS_PER_BEAT, cpb);
      repeat (4) add_track(chan, pass);
      if (grp == 5) add_drain();
      grp++;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_q.size() == 0);
    @(posedge clk_i);
    while (push || cfg_valid_i || event_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("covered %0d bytes over %0d tracks, %0d events checked",
             n_items, n_tracks, n_events);
    if (n_errors == 0 && event_q.size() == 0 && empty) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
design/mtep_pkg.sv
design/mtep_front.sv
design/mtep_queue.sv
design/mtep_back.sv
design/midi_track_event_parser.sv
sim/tb_top.sv
